// ===== design/sicv_pkg.sv =====
// Shared types, constants and the CRC-32/MPEG-2 word fold for the staged image CRC verifier.
`default_nettype none

package sicv_pkg;

    localparam int unsigned DEF_PAYLOAD_WORDS = 16;
    localparam int unsigned DEF_SLOT_COUNT    = 2;

    localparam int unsigned CRC_W       = 32;
    localparam int unsigned SLOT_W      = 8;
    localparam int unsigned WORDS_W     = 16;
    localparam int unsigned VERSION_W   = 4;
    localparam int unsigned STAMP_W     = 16;
    localparam int unsigned S_TDATA_W   = 96;
    localparam int unsigned M_TDATA_W   = 64;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic {
        CMD_BEGIN = 1'b0,
        CMD_DATA  = 1'b1
    } sicv_cmd_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_STAGING = 2'd1,
        ST_MISMATCH    = 2'd2
    } sicv_status_t;

    typedef struct packed {
        sicv_cmd_t              command;
        logic [SLOT_W-1:0]      target_slot;
        logic [WORDS_W-1:0]     declared_words;
        logic [VERSION_W-1:0]   image_version;
        logic [CRC_W-1:0]       expected_crc;
        logic [CRC_W-1:0]       data_word;
    } sicv_item_t;

    typedef struct packed {
        sicv_status_t           status;
        logic [CRC_W-1:0]       computed_crc;
        logic [SLOT_W-1:0]      result_slot;
        logic [VERSION_W-1:0]   result_version;
        logic [STAMP_W-1:0]     event_stamp;
    } sicv_result_t;

    // Folds one word MSB first; the loop is a fixed XOR network after unrolling.
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [CRC_W-1:0] word);
        logic [CRC_W-1:0] c;
        c = crc ^ word;
        for (int k = 0; k < CRC_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/sicv_in_reg.sv =====
// Input register stage holding one accepted transaction until the check core takes it.
`default_nettype none

module sicv_in_reg (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sicv_pkg::sicv_item_t in_item,
    input  wire logic                take,
    output logic                     item_valid,
    output sicv_pkg::sicv_item_t     item
);
    import sicv_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    sicv_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/sicv_core.sv =====
// Session state, CRC fold, comparison and event stamp of the verifier.
`default_nettype none

module sicv_core #(
    parameter int unsigned PAYLOAD_WORDS = sicv_pkg::DEF_PAYLOAD_WORDS,
    parameter int unsigned SLOT_COUNT    = sicv_pkg::DEF_SLOT_COUNT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 advance,
    input  wire sicv_pkg::sicv_item_t item,
    output logic                      emit,
    output sicv_pkg::sicv_result_t    result
);
    import sicv_pkg::*;

    localparam int unsigned CNT_W = $clog2(PAYLOAD_WORDS + 1);

    logic [CRC_W-1:0]     running_crc_reg, running_crc_next;
    logic [CNT_W-1:0]     words_seen_reg, words_seen_next;
    logic                 session_open_reg, session_open_next;
    logic [SLOT_W-1:0]    latched_slot_reg, latched_slot_next;
    logic [VERSION_W-1:0] latched_version_reg, latched_version_next;
    logic [CRC_W-1:0]     latched_expected_reg, latched_expected_next;
    logic [STAMP_W-1:0]   event_counter_reg, event_counter_next;

    logic [CRC_W-1:0]     folded;
    logic [CNT_W-1:0]     words_inc;
    logic                 last_word;
    logic                 bad_staging;
    logic                 crc_match;
    logic [STAMP_W-1:0]   stamp_inc;

    assign folded      = crc_fold(running_crc_reg, item.data_word);
    assign words_inc   = words_seen_reg + CNT_W'(1);
    assign last_word   = (words_inc == CNT_W'(PAYLOAD_WORDS));
    assign bad_staging = ({1'b0, item.target_slot} >= (SLOT_W + 1)'(SLOT_COUNT))
                      || (item.declared_words != WORDS_W'(PAYLOAD_WORDS));
    assign crc_match   = (folded == latched_expected_reg);
    assign stamp_inc   = event_counter_reg + STAMP_W'(1);

    always_comb begin
        running_crc_next      = running_crc_reg;
        words_seen_next       = words_seen_reg;
        session_open_next     = session_open_reg;
        latched_slot_next     = latched_slot_reg;
        latched_version_next  = latched_version_reg;
        latched_expected_next = latched_expected_reg;
        event_counter_next    = event_counter_reg;
        emit                  = 1'b0;
        result.status         = ST_OK;
        result.computed_crc   = folded;
        result.result_slot    = latched_slot_reg;
        result.result_version = latched_version_reg;
        result.event_stamp    = '0;

        if (item.command == CMD_BEGIN) begin
            // A begin always abandons any open session.
            emit                  = bad_staging;
            result.status         = ST_BAD_STAGING;
            result.computed_crc   = '0;
            result.result_slot    = item.target_slot;
            result.result_version = item.image_version;
            if (advance) begin
                running_crc_next      = CRC_INIT;
                words_seen_next       = '0;
                session_open_next     = !bad_staging;
                latched_slot_next     = item.target_slot;
                latched_version_next  = item.image_version;
                latched_expected_next = item.expected_crc;
            end
        end else if (session_open_reg) begin
            emit = last_word;
            if (crc_match) begin
                result.status      = ST_OK;
                result.event_stamp = stamp_inc;
            end else begin
                result.status = ST_MISMATCH;
            end
            if (advance) begin
                running_crc_next = folded;
                if (last_word) begin
                    words_seen_next   = '0;
                    session_open_next = 1'b0;
                    if (crc_match) begin
                        event_counter_next = stamp_inc;
                    end
                end else begin
                    words_seen_next = words_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_crc_reg   <= CRC_INIT;
            words_seen_reg    <= '0;
            session_open_reg  <= 1'b0;
            event_counter_reg <= '0;
        end else begin
            running_crc_reg   <= running_crc_next;
            words_seen_reg    <= words_seen_next;
            session_open_reg  <= session_open_next;
            event_counter_reg <= event_counter_next;
        end
    end

    always_ff @(posedge aclk) begin
        latched_slot_reg     <= latched_slot_next;
        latched_version_reg  <= latched_version_next;
        latched_expected_reg <= latched_expected_next;
    end

endmodule

`default_nettype wire

// ===== design/sicv_out_reg.sv =====
// Result register that holds one finished result until the downstream side takes it.
`default_nettype none

module sicv_out_reg (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   load,
    input  wire sicv_pkg::sicv_result_t load_result,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output sicv_pkg::sicv_result_t      out_result
);
    import sicv_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    sicv_result_t result_reg;

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= load_result;
        end
    end

endmodule

`default_nettype wire

// ===== design/staged_image_crc_verifier_unit.sv =====
// Top level of the staged image CRC verifier: stream ports, input register, core, result register.
`default_nettype none

// Channel   Direction  Ports                         Contents
// s_        in         s_tvalid/s_tready/s_tdata/    begin or payload word transaction
//                      s_tuser
// m_        out        m_tvalid/m_tready/m_tdata/    verdict transaction (ok, bad staging,
//                      m_tuser                       mismatch)
//
// Each transaction waits in the input register and is folded into the session state as it
// leaves; any result it produces is loaded into the result register on that same edge, and
// one transaction can be taken every cycle unless a new result would overwrite one still
// waiting for m_tready. The unrolled 32-bit CRC fold lies between the two registers.
// Reset (aresetn low, synchronous) empties both registers, closes any session and clears
// the event stamp. When m_tready stays low, transactions that produce no result still
// drain through; one that would produce a result waits in the input register.
module staged_image_crc_verifier_unit #(
    parameter int unsigned PAYLOAD_WORDS = sicv_pkg::DEF_PAYLOAD_WORDS,
    parameter int unsigned SLOT_COUNT    = sicv_pkg::DEF_SLOT_COUNT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // target_slot[7:0], declared_words[23:8], image_version[27:24],
    // expected_crc[59:28], data_word[91:60], zero fill[95:92]
    input  wire logic [sicv_pkg::S_TDATA_W-1:0] s_tdata,
    // command[0]: 0 begin update check, 1 payload data word
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // computed_crc[31:0], result_slot[39:32], result_version[43:40],
    // event_stamp[59:44], zero fill[63:60]
    output logic [sicv_pkg::M_TDATA_W-1:0]      m_tdata,
    // status[1:0]: 0 crc ok, 1 bad staging, 2 crc mismatch
    output logic [1:0]                          m_tuser
);
    import sicv_pkg::*;

    sicv_item_t   s_item;
    sicv_item_t   item;
    logic         item_valid;
    logic         advance;
    logic         emit;
    sicv_result_t core_result;
    sicv_result_t out_result;

    // Unpack the incoming transaction into its fields.
    always_comb begin
        s_item.command        = sicv_cmd_t'(s_tuser);
        s_item.target_slot    = s_tdata[7:0];
        s_item.declared_words = s_tdata[23:8];
        s_item.image_version  = s_tdata[27:24];
        s_item.expected_crc   = s_tdata[59:28];
        s_item.data_word      = s_tdata[91:60];
    end

    // The held transaction moves on unless it produces a result that would
    // overwrite one still waiting downstream.
    assign advance = item_valid && (!emit || !m_tvalid || m_tready);

    sicv_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (s_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sicv_core #(
        .PAYLOAD_WORDS (PAYLOAD_WORDS),
        .SLOT_COUNT    (SLOT_COUNT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .emit    (emit),
        .result  (core_result)
    );

    sicv_out_reg u_out_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance && emit),
        .load_result (core_result),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_result  (out_result)
    );

    // Pack the result fields, lowest field first, with zero fill to a whole byte.
    assign m_tdata = {4'd0, out_result.event_stamp, out_result.result_version,
                      out_result.result_slot, out_result.computed_crc};
    assign m_tuser = out_result.status;

endmodule

`default_nettype wire

// ===== sim/staged_image_crc_verifier_unit_tb.sv =====
// Self-checking testbench for the staged image CRC verifier: stream stimulus, verdict prediction.
module staged_image_crc_verifier_unit_tb;
    import sicv_pkg::*;

    localparam int unsigned PAYLOAD_WORDS = DEF_PAYLOAD_WORDS;
    localparam int unsigned SLOT_COUNT    = DEF_SLOT_COUNT;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned DRAIN_CYCLES  = 10;
    localparam int unsigned HOLD_OFF      = 300;

    // Receiver stall patterns.
    localparam int RX_ALWAYS   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    // Shadow of the block's session state, kept by the verdict predictor.
    logic [CRC_W-1:0]     shadow_crc;
    int unsigned          shadow_words;
    bit                   shadow_open;
    logic [SLOT_W-1:0]    shadow_slot;
    logic [VERSION_W-1:0] shadow_version;
    logic [CRC_W-1:0]     shadow_expected;
    logic [STAMP_W-1:0]   shadow_stamp;

    sicv_result_t pending_verdicts[$];
    int unsigned  error_count;
    int unsigned  live_items;
    int unsigned  cycle_count = 0;

    // Sender and receiver pacing, set by the test tasks.
    int unsigned  tx_gap_max;
    int unsigned  tx_burst_left;
    int           rx_mode;
    int unsigned  rx_phase;
    int unsigned  hold_left;

    staged_image_crc_verifier_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // CRC-32/MPEG-2 over one word, one message bit at a time from the top bit down.
    function automatic logic [CRC_W-1:0] fold_crc_word(input logic [CRC_W-1:0] crc,
                                                       input logic [CRC_W-1:0] word);
        logic [CRC_W-1:0] acc;
        logic             feedback;
        acc = crc;
        for (int i = CRC_W - 1; i >= 0; i--) begin
            feedback = acc[CRC_W-1] ^ word[i];
            acc = acc << 1;
            if (feedback) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    // Works out the verdict, if any, that one accepted transaction causes.
    task automatic track_image_check(input sicv_item_t it);
        sicv_result_t r;
        if (it.command == CMD_BEGIN) begin
            // A begin always abandons whatever session was open.
            live_items++;
            shadow_open  = 1'b0;
            shadow_crc   = CRC_INIT;
            shadow_words = 0;
            if (it.target_slot >= SLOT_COUNT || it.declared_words != PAYLOAD_WORDS) begin
                r.status         = ST_BAD_STAGING;
                r.computed_crc   = '0;
                r.result_slot    = it.target_slot;
                r.result_version = it.image_version;
                r.event_stamp    = '0;
                pending_verdicts.push_back(r);
            end else begin
                shadow_slot     = it.target_slot;
                shadow_version  = it.image_version;
                shadow_expected = it.expected_crc;
                shadow_open     = 1'b1;
            end
        end else if (shadow_open) begin
            live_items++;
            shadow_crc = fold_crc_word(shadow_crc, it.data_word);
            shadow_words++;
            if (shadow_words == PAYLOAD_WORDS) begin
                shadow_open      = 1'b0;
                shadow_words     = 0;
                r.computed_crc   = shadow_crc;
                r.result_slot    = shadow_slot;
                r.result_version = shadow_version;
                if (shadow_crc == shadow_expected) begin
                    shadow_stamp  = shadow_stamp + 1'b1;
                    r.status      = ST_OK;
                    r.event_stamp = shadow_stamp;
                end else begin
                    r.status      = ST_MISMATCH;
                    r.event_stamp = '0;
                end
                pending_verdicts.push_back(r);
            end
        end
    endtask

    // Drives one transaction from the falling edge and holds it until the block takes it.
    task automatic send_item(input sicv_item_t it);
        int unsigned gap;
        if (tx_burst_left == 0) begin
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
            tx_burst_left = $urandom_range(1, 12);
        end
        tx_burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.command;
        s_tdata  <= {4'b0, it.data_word, it.expected_crc, it.image_version,
                     it.declared_words, it.target_slot};
        @(posedge aclk);
        while (s_tready !== 1'b1) begin
            @(posedge aclk);
        end
        track_image_check(it);
    endtask

    task automatic idle_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Fields a transaction does not use are filled at random; the block must ignore them.
    function automatic sicv_item_t make_begin(input logic [SLOT_W-1:0] slot,
                                              input logic [WORDS_W-1:0] words,
                                              input logic [VERSION_W-1:0] ver,
                                              input logic [CRC_W-1:0] crc);
        sicv_item_t it;
        it.command        = CMD_BEGIN;
        it.target_slot    = slot;
        it.declared_words = words;
        it.image_version  = ver;
        it.expected_crc   = crc;
        it.data_word      = $urandom;
        return it;
    endfunction

    function automatic sicv_item_t make_data(input logic [CRC_W-1:0] word);
        sicv_item_t it;
        it.command        = CMD_DATA;
        it.target_slot    = SLOT_W'($urandom);
        it.declared_words = WORDS_W'($urandom);
        it.image_version  = VERSION_W'($urandom);
        it.expected_crc   = $urandom;
        it.data_word      = word;
        return it;
    endfunction

    // Sends a well-formed begin and the first n_data payload words of its image. The trailer
    // CRC is right when good is set; corner puts all zeros first and all ones last.
    task automatic send_session(input logic [SLOT_W-1:0] slot, input logic [VERSION_W-1:0] ver,
                                input int unsigned n_data, input bit good, input bit corner);
        logic [CRC_W-1:0] words [PAYLOAD_WORDS];
        logic [CRC_W-1:0] crc;
        logic [CRC_W-1:0] trailer;
        int unsigned      pick;
        crc = CRC_INIT;
        for (int i = 0; i < PAYLOAD_WORDS; i++) begin
            pick = $urandom_range(0, 9);
            if (corner && i == 0) begin
                words[i] = '0;
            end else if (corner && i == PAYLOAD_WORDS - 1) begin
                words[i] = '1;
            end else begin
                words[i] = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
            end
            crc = fold_crc_word(crc, words[i]);
        end
        trailer = good ? crc : $urandom;
        if (!good && trailer == crc) begin
            trailer = ~crc;
        end
        send_item(make_begin(slot, WORDS_W'(PAYLOAD_WORDS), ver, trailer));
        for (int i = 0; i < n_data; i++) begin
            send_item(make_data(words[i]));
        end
    endtask

    // A begin that must be refused: slot out of range, or a word count other than the payload.
    task automatic send_bad_begin();
        logic [SLOT_W-1:0]  slot;
        logic [WORDS_W-1:0] words;
        slot  = SLOT_W'($urandom);
        words = ($urandom_range(0, 1) == 0) ? WORDS_W'(PAYLOAD_WORDS) : WORDS_W'($urandom);
        if (slot < SLOT_COUNT && words == PAYLOAD_WORDS) begin
            words = words ^ WORDS_W'($urandom_range(1, 65535));
        end
        send_item(make_begin(slot, words, VERSION_W'($urandom), $urandom));
    endtask

    task automatic test_bad_staging();
        send_item(make_begin(8'hFF, WORDS_W'(PAYLOAD_WORDS), 4'hF, 32'hFFFF_FFFF));
        send_item(make_begin(8'(SLOT_COUNT), WORDS_W'(PAYLOAD_WORDS), 4'h5, 32'h0));
        send_item(make_begin(8'h00, 16'h0000, 4'h0, 32'h1234_5678));
        send_item(make_begin(8'(SLOT_COUNT - 1), 16'hFFFF, 4'h0, 32'hFFFF_FFFF));
    endtask

    task automatic test_stray_data();
        send_item(make_data(32'h0000_0000));
        send_item(make_data(32'hFFFF_FFFF));
    endtask

    // The next test's begin arrives mid-session, so this session closes without a verdict.
    task automatic test_abandoned_session();
        send_session(8'h01, 4'hA, 1, 1'b1, 1'b0);
    endtask

    task automatic test_crc_ok();
        send_session(8'h00, 4'hF, PAYLOAD_WORDS, 1'b1, 1'b1);
    endtask

    task automatic test_crc_mismatch();
        send_session(8'(SLOT_COUNT - 1), 4'h0, PAYLOAD_WORDS, 1'b0, 1'b1);
    endtask

    // The receiver holds off for a long stretch while refused begins and full sessions keep
    // arriving back to back, so the block fills up and must stall its input.
    task automatic test_back_pressure();
        tx_gap_max = 0;
        hold_left  = HOLD_OFF;
        for (int i = 0; i < 30; i++) begin
            send_bad_begin();
        end
        send_session(8'h00, VERSION_W'($urandom), PAYLOAD_WORDS, 1'b1, 1'b0);
        send_session(8'h01, VERSION_W'($urandom), PAYLOAD_WORDS, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned group;
        int unsigned choice;
        goal  = live_items + 700;
        group = 0;
        while (live_items < goal) begin
            // Change the pacing of both sides every few groups; some phases run flat out.
            if (group % 8 == 0) begin
                choice = $urandom_range(0, 2);
                tx_gap_max = (choice == 0) ? 0 : (choice == 1) ? 2 : 8;
                rx_mode    = $urandom_range(RX_ALWAYS, RX_PERIODIC);
            end
            group++;
            choice = $urandom_range(0, 99);
            if (choice < 65) begin
                send_session(SLOT_W'($urandom_range(0, SLOT_COUNT - 1)), VERSION_W'($urandom),
                             PAYLOAD_WORDS, $urandom_range(0, 3) != 0, 1'b0);
            end else if (choice < 80) begin
                send_bad_begin();
            end else if (choice < 90) begin
                send_item(make_data($urandom));
            end else begin
                send_session(SLOT_W'($urandom_range(0, SLOT_COUNT - 1)), VERSION_W'($urandom),
                             $urandom_range(0, PAYLOAD_WORDS - 1), 1'b1, 1'b0);
            end
        end
    endtask

    // Receiver: a long hold-off when asked, otherwise the current stall pattern.
    initial begin
        m_tready = 1'b1;
        rx_phase = 0;
        forever begin
            @(negedge aclk);
            rx_phase++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_RANDOM: begin
                        m_tready <= ($urandom_range(0, 3) != 0);
                    end
                    RX_PERIODIC: begin
                        m_tready <= (rx_phase % 7 > 2);
                    end
                    default: begin
                        m_tready <= 1'b1;
                    end
                endcase
            end
        end
    end

    function automatic void compare_field(input string name, input logic [CRC_W-1:0] want,
                                          input logic [CRC_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Each verdict transaction is checked against the oldest prediction.
    always @(posedge aclk) begin : verdict_check
        sicv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("verdict: none expected, got status %0d tdata 0x%0h", m_tuser, m_tdata);
                error_count++;
            end else begin
                want = pending_verdicts.pop_front();
                compare_field("status", 32'(want.status), 32'(m_tuser));
                compare_field("computed_crc", want.computed_crc, m_tdata[31:0]);
                compare_field("result_slot", 32'(want.result_slot), 32'(m_tdata[39:32]));
                compare_field("result_version", 32'(want.result_version),
                              32'(m_tdata[43:40]));
                compare_field("event_stamp", 32'(want.event_stamp), 32'(m_tdata[59:44]));
            end
        end
    end

    initial begin
        error_count     = 0;
        live_items      = 0;
        hold_left       = 0;
        rx_mode         = RX_ALWAYS;
        tx_gap_max      = 2;
        tx_burst_left   = 0;
        shadow_crc      = CRC_INIT;
        shadow_words    = 0;
        shadow_open     = 1'b0;
        shadow_slot     = '0;
        shadow_version  = '0;
        shadow_expected = '0;
        shadow_stamp    = '0;
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        rx_mode = RX_RANDOM;
        test_bad_staging();
        test_stray_data();
        test_abandoned_session();
        test_crc_ok();
        test_crc_mismatch();
        test_back_pressure();
        test_random_traffic();

        idle_input();
        rx_mode = RX_ALWAYS;
        while (pending_verdicts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_verdicts.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
